// File: rtl/kwft_pkg.sv
// Shared constants and types for the keyed window failure tracker.
`timescale 1ns / 1ps
package kwft_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;

	localparam int KEY_W    = 32;
	localparam int TIME_W   = 32;
	localparam int COUNT_W  = 16;
	localparam int WIN_W    = 16;
	localparam int THR_W    = 8;
	localparam int TOTAL_W  = 32;
	localparam int ENTRY_W  = KEY_W + TIME_W + COUNT_W;

	localparam logic [WIN_W-1:0]   WINDOW_RESET    = 16'd60;
	localparam logic [THR_W-1:0]   THRESHOLD_RESET = 8'd5;
	localparam logic [COUNT_W-1:0] COUNT_MAX       = 16'hFFFF;

	// register select is paddr[2]
	localparam logic REG_WINDOW    = 1'b0;
	localparam logic REG_THRESHOLD = 1'b1;

	typedef enum logic [2:0] {
		OC_IGNORED  = 3'd0,
		OC_RESTART  = 3'd1,
		OC_COUNTED  = 3'd2,
		OC_INSERTED = 3'd3,
		OC_DROPPED  = 3'd4
	} outcome_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [TIME_W-1:0]  start;
		logic [COUNT_W-1:0] count;
	} entry_t;

endpackage

// File: rtl/kwft_ram.sv
// Generic single write port, single registered read port RAM.
`timescale 1ns / 1ps
module kwft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/keyed_window_failure_tracker_unit.sv
// Top level of the keyed window failure tracker: table walk, update and stream ports.
`timescale 1ns / 1ps
// Tracks failure events per IPv4 source address in a table of TABLE_ENTRIES
// entries held in one synchronous RAM (key, window start, count per entry).
// Each request carries key_valid in s_axis_tuser and the address and time in
// s_axis_tdata. An event without a key is answered at once as ignored. Other
// events walk the table from entry 0 in insertion order, one read a cycle on
// the single RAM read port: a hit either restarts the window (time since
// window start greater than window_seconds, never on negative differences) or
// bumps the saturating count, raising an alert when it equals alert_threshold;
// a miss appends the key with a count of 1, or drops it once the table is full.
// Entries are never removed. One request is in flight at a time; a request
// walks the entries in use through the registered read port, then an update
// or insert state (none on a drop) and the output state before its result is
// offered; an event without a key goes straight to the output state. The
// next request is accepted back in idle, and may be accepted while that result
// still waits in the output register. Registers
// on the APB port (window_seconds at 0x0, alert_threshold at 0x4) are to be
// written only while the block is idle. No clearing pass is needed after reset.
module keyed_window_failure_tracker_unit
	import kwft_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // [31:0] source_address, [63:32] event_time
	input  logic        s_axis_tuser,  // [0] key_valid
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // [0] alert, [16:1] current_count,
	                                   // [48:17] alerts_so_far, [55:49] zero
	output logic [2:0]  m_axis_tuser   // [2:0] outcome
);

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_INSERT,
		ST_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [WIN_W-1:0] window_q;
	logic [THR_W-1:0] thr_q;

	// request being worked on
	logic [KEY_W-1:0]  key_q;
	logic [TIME_W-1:0] now_q;

	// table walk
	logic [CW-1:0] used_q;
	logic [CW-1:0] idx_q;
	logic          pend_s1;
	logic [IW-1:0] idx_s1;

	// hit entry
	logic [IW-1:0]      hit_idx_q;
	logic [TIME_W-1:0]  hit_start_q;
	logic [COUNT_W-1:0] hit_cnt_q;

	// result
	logic               res_alert_q;
	outcome_t           res_outcome_q;
	logic [COUNT_W-1:0] res_count_q;
	logic [TOTAL_W-1:0] alert_total_q;

	logic               m_valid_q;
	logic [55:0]        m_data_q;
	logic [2:0]         m_user_q;

	// RAM
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	entry_t        ram_wdata;
	entry_t        ram_rdata;
	logic [ENTRY_W-1:0] ram_rbits;

	kwft_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q[IW-1:0]),
		.rdata (ram_rbits)
	);

	assign ram_rdata = entry_t'(ram_rbits);

	// update arithmetic on the hit entry
	logic [TIME_W-1:0]  age;
	logic               expired;
	logic               saturated;
	logic [COUNT_W-1:0] cnt_inc;
	logic               hit_alert;

	assign age       = now_q - hit_start_q;
	// a negative difference never expires
	assign expired   = (now_q > hit_start_q) && (age > {{(TIME_W-WIN_W){1'b0}}, window_q});
	assign saturated = (hit_cnt_q == COUNT_MAX);
	assign cnt_inc   = saturated ? hit_cnt_q : hit_cnt_q + 16'd1;
	assign hit_alert = !saturated && (cnt_inc == {{(COUNT_W-THR_W){1'b0}}, thr_q});

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = hit_idx_q;
		ram_wdata = '{key: key_q, start: hit_start_q, count: cnt_inc};
		case (state_q)
			ST_UPDATE: begin
				ram_we = 1'b1;
				if (expired) begin
					ram_wdata = '{key: key_q, start: now_q, count: 16'd1};
				end
			end
			ST_INSERT: begin
				ram_we    = 1'b1;
				ram_waddr = used_q[IW-1:0];
				ram_wdata = '{key: key_q, start: now_q, count: 16'd1};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	logic out_free;
	assign out_free = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			used_q        <= '0;
			idx_q         <= '0;
			pend_s1       <= 1'b0;
			alert_total_q <= '0;
			m_valid_q     <= 1'b0;
		end else begin
			// load a new result, or retire the one taken downstream
			if (state_q == ST_OUT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						idx_q   <= '0;
						pend_s1 <= 1'b0;
						if (s_axis_tuser) begin
							state_q <= ST_SCAN;
						end else begin
							res_alert_q   <= 1'b0;
							res_outcome_q <= OC_IGNORED;
							res_count_q   <= '0;
							state_q       <= ST_OUT;
						end
					end
				end
				ST_SCAN: begin
					// issue the next read while comparing the previous one
					if (idx_q != used_q) begin
						idx_q   <= idx_q + 1'b1;
						idx_s1  <= idx_q[IW-1:0];
						pend_s1 <= 1'b1;
					end else begin
						pend_s1 <= 1'b0;
					end
					if (pend_s1 && ram_rdata.key == key_q) begin
						hit_idx_q   <= idx_s1;
						hit_start_q <= ram_rdata.start;
						hit_cnt_q   <= ram_rdata.count;
						state_q     <= ST_UPDATE;
					end else if (!pend_s1 && idx_q == used_q) begin
						if (used_q == FULL) begin
							res_alert_q   <= 1'b0;
							res_outcome_q <= OC_DROPPED;
							res_count_q   <= '0;
							state_q       <= ST_OUT;
						end else begin
							state_q <= ST_INSERT;
						end
					end
				end
				ST_UPDATE: begin
					if (expired) begin
						res_alert_q   <= 1'b0;
						res_outcome_q <= OC_RESTART;
						res_count_q   <= 16'd1;
					end else begin
						res_alert_q   <= hit_alert;
						res_outcome_q <= OC_COUNTED;
						res_count_q   <= cnt_inc;
						if (hit_alert) begin
							alert_total_q <= alert_total_q + 1'b1;
						end
					end
					state_q <= ST_OUT;
				end
				ST_INSERT: begin
					used_q        <= used_q + 1'b1;
					res_alert_q   <= 1'b0;
					res_outcome_q <= OC_INSERTED;
					res_count_q   <= 16'd1;
					state_q       <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						m_data_q  <= {7'd0, alert_total_q, res_count_q, res_alert_q};
						m_user_q  <= res_outcome_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request payload capture
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid) begin
			key_q <= s_axis_tdata[31:0];
			now_q <= s_axis_tdata[63:32];
		end
	end

	// configuration registers
	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
			thr_q    <= THRESHOLD_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_WINDOW) begin
				window_q <= pwdata[WIN_W-1:0];
			end else begin
				thr_q <= pwdata[THR_W-1:0];
			end
		end
	end

	always_comb begin
		case (paddr[2])
			REG_WINDOW:    prdata = {16'd0, window_q};
			REG_THRESHOLD: prdata = {24'd0, thr_q};
			default:       prdata = '0;
		endcase
	end

	assign pready        = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule
